@@ rtl/core/gbe_pkg.sv @@
// shared types, codes and helper functions for the gap buffer editor
package gbe_pkg;

	localparam int CAPACITY_DEF = 4096;
	localparam int POS_W        = 13;
	localparam int BYTE_W       = 8;
	localparam int CMD_W        = 3;
	localparam int STAT_W       = 2;
	localparam int LEN_W        = 3;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT    = 3'd0,
		CMD_BACKSPACE = 3'd1,
		CMD_DELETE    = 3'd2,
		CMD_LEFT      = 3'd3,
		CMD_RIGHT     = 3'd4,
		CMD_CLEAR     = 3'd5
	} cmd_t;

	localparam logic [STAT_W-1:0] ST_DONE = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
	localparam logic [STAT_W-1:0] ST_NOOP = 2'd2;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic              next_valid;
		logic [BYTE_W-1:0] next_byte;
		logic [POS_W-1:0]  text_length;
		logic [POS_W-1:0]  cursor_pos;
	} result_t;

	// continuation bytes are 10xxxxxx
	function automatic logic is_cont(input logic [BYTE_W-1:0] b);
		return (b & 8'hC0) == 8'h80;
	endfunction

	// character length from its lead byte
	function automatic logic [LEN_W-1:0] char_len(input logic [BYTE_W-1:0] lead);
		logic [LEN_W-1:0] n;
		if (lead <= 8'h7F || lead < 8'hC0) n = 3'd1;
		else if (lead < 8'hE0) n = 3'd2;
		else if (lead < 8'hF0) n = 3'd3;
		else if (lead < 8'hF8) n = 3'd4;
		else if (lead < 8'hFC) n = 3'd5;
		else n = 3'd6;
		return n;
	endfunction

endpackage

@@ rtl/core/utf8_gap_buffer_editor.sv @@
// Gap buffer text editor with a byte store of CAPACITY entries and UTF-8 aware
// cursor moves. One command is taken at a time. Insert, backspace, delete,
// clear and refused commands copy nothing, while a cursor move copies bytes
// across the gap one by one, and a left move that stops on a lead byte also
// reads that byte. The pace is set by the single read port of the text store:
// each copied byte needs a read and the write back, and a last read fetches
// the byte after the cursor. The result sits in an output register, so the
// next command is taken while a result still waits to be taken.
module utf8_gap_buffer_editor #(
	parameter int CAPACITY = gbe_pkg::CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // data_byte
	input  logic [2:0]  s_tuser,   // cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata    // cursor_pos, text_length, next_byte, next_valid, status
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	logic                       mem_we, mem_re;
	logic [AW-1:0]              mem_waddr, mem_raddr;
	logic [gbe_pkg::BYTE_W-1:0] mem_wdata, mem_rdata;
	logic                       res_valid, res_ready;
	gbe_pkg::result_t           res;
	logic                       out_valid_q;
	gbe_pkg::result_t           out_q;

	gbe_text_ram #(
		.CAPACITY(CAPACITY),
		.AW      (AW)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	gbe_seq #(
		.CAPACITY(CAPACITY),
		.AW      (AW),
		.CW      (CW)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(s_tvalid),
		.cmd_ready(s_tready),
		.cmd      (s_tuser),
		.data_byte(s_tdata),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_re   (mem_re),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	// output register frees up as soon as its transfer completes
	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_q.status, out_q.next_valid, out_q.next_byte,
		out_q.text_length, out_q.cursor_pos};

endmodule

@@ rtl/core/gbe_text_ram.sv @@
// text store: one write port, one registered read port
module gbe_text_ram #(
	parameter int CAPACITY = gbe_pkg::CAPACITY_DEF,
	parameter int AW       = $clog2(CAPACITY)
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic [gbe_pkg::BYTE_W-1:0] wdata,
	input  logic                      re,
	input  logic [AW-1:0]             raddr,
	output logic [gbe_pkg::BYTE_W-1:0] rdata
);

	logic [gbe_pkg::BYTE_W-1:0] mem [CAPACITY];
	logic [gbe_pkg::BYTE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/core/gbe_seq.sv @@
// command sequencer: gap pointers and read-modify-write of the text store
module gbe_seq #(
	parameter int CAPACITY = gbe_pkg::CAPACITY_DEF,
	parameter int AW       = $clog2(CAPACITY),
	parameter int CW       = $clog2(CAPACITY + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cmd_valid,
	output logic                       cmd_ready,
	input  logic [gbe_pkg::CMD_W-1:0]  cmd,
	input  logic [gbe_pkg::BYTE_W-1:0] data_byte,
	output logic                       res_valid,
	input  logic                       res_ready,
	output gbe_pkg::result_t           res,
	output logic                       mem_we,
	output logic [AW-1:0]              mem_waddr,
	output logic [gbe_pkg::BYTE_W-1:0] mem_wdata,
	output logic                       mem_re,
	output logic [AW-1:0]              mem_raddr,
	input  logic [gbe_pkg::BYTE_W-1:0] mem_rdata
);

	localparam logic [CW-1:0] CAP_W = CW'(CAPACITY);
	localparam int            OW    = gbe_pkg::POS_W;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_EXEC  = 8'b0000_0010,
		S_LREAD = 8'b0000_0100,
		S_LMOVE = 8'b0000_1000,
		S_RREAD = 8'b0001_0000,
		S_RMOVE = 8'b0010_0000,
		S_FREAD = 8'b0100_0000,
		S_FOUT  = 8'b1000_0000
	} state_t;

	state_t                        state_q, state_d;
	logic [gbe_pkg::CMD_W-1:0]     cmd_q;
	logic [gbe_pkg::BYTE_W-1:0]    data_q;
	logic [CW-1:0]                 gb_q, gb_d;
	logic [CW-1:0]                 ge_q, ge_d;
	logic                          first_q, first_d;
	logic [gbe_pkg::LEN_W-1:0]     rem_q, rem_d;
	logic [gbe_pkg::STAT_W-1:0]    st_q, st_d;

	logic [CW-1:0]                 gb_m1, ge_m1, room, lead_len, mv_cnt;
	logic [gbe_pkg::LEN_W-1:0]     rem_eff;
	logic                          nv;
	logic [CW-1:0]                 tlen;
	logic [CW+OW-1:0]              pos_ext, len_ext;

	assign gb_m1    = gb_q - 1'b1;
	assign ge_m1    = ge_q - 1'b1;
	assign room     = CAP_W - ge_q;
	assign lead_len = CW'(gbe_pkg::char_len(mem_rdata));
	// clamp the character to the bytes left after the cursor
	assign mv_cnt   = (room < lead_len) ? room : lead_len;
	assign rem_eff  = first_q ? (mv_cnt[gbe_pkg::LEN_W-1:0] - 1'b1) : rem_q;

	assign nv      = ge_q < CAP_W;
	assign tlen    = gb_q + room;
	assign pos_ext = {{OW{1'b0}}, gb_q};
	assign len_ext = {{OW{1'b0}}, tlen};

	always_comb begin
		state_d   = state_q;
		gb_d      = gb_q;
		ge_d      = ge_q;
		first_d   = first_q;
		rem_d     = rem_q;
		st_d      = st_q;
		mem_we    = 1'b0;
		mem_waddr = gb_q[AW-1:0];
		mem_wdata = data_q;
		mem_re    = 1'b0;
		mem_raddr = ge_q[AW-1:0];
		cmd_ready = 1'b0;
		res_valid = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				cmd_ready = 1'b1;
				st_d      = gbe_pkg::ST_DONE;
				if (cmd_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_FREAD;
				first_d = 1'b1;
				unique case (cmd_q)
					gbe_pkg::CMD_INSERT: begin
						if (gb_q < ge_q) begin
							mem_we = 1'b1;
							gb_d   = gb_q + 1'b1;
						end else begin
							st_d = gbe_pkg::ST_FULL;
						end
					end
					gbe_pkg::CMD_BACKSPACE: begin
						if (gb_q != '0) gb_d = gb_m1;
						else st_d = gbe_pkg::ST_NOOP;
					end
					gbe_pkg::CMD_DELETE: begin
						if (nv) ge_d = ge_q + 1'b1;
						else st_d = gbe_pkg::ST_NOOP;
					end
					gbe_pkg::CMD_LEFT: begin
						if (gb_q != '0) begin
							mem_re    = 1'b1;
							mem_raddr = gb_m1[AW-1:0];
							state_d   = S_LMOVE;
						end else begin
							st_d = gbe_pkg::ST_NOOP;
						end
					end
					gbe_pkg::CMD_RIGHT: begin
						if (nv) begin
							mem_re  = 1'b1;
							state_d = S_RMOVE;
						end else begin
							st_d = gbe_pkg::ST_NOOP;
						end
					end
					gbe_pkg::CMD_CLEAR: begin
						gb_d = '0;
						ge_d = CAP_W;
					end
					default: st_d = gbe_pkg::ST_NOOP;
				endcase
			end
			S_LREAD: begin
				mem_re    = 1'b1;
				mem_raddr = gb_m1[AW-1:0];
				state_d   = S_LMOVE;
			end
			S_LMOVE: begin
				// a lead byte before the cursor ends the move without copying
				if (first_q || gbe_pkg::is_cont(mem_rdata)) begin
					mem_we    = 1'b1;
					mem_waddr = ge_m1[AW-1:0];
					mem_wdata = mem_rdata;
					gb_d      = gb_m1;
					ge_d      = ge_m1;
					first_d   = 1'b0;
					state_d   = (gb_m1 == '0) ? S_FREAD : S_LREAD;
				end else begin
					state_d = S_FREAD;
				end
			end
			S_RREAD: begin
				mem_re  = 1'b1;
				state_d = S_RMOVE;
			end
			S_RMOVE: begin
				mem_we    = 1'b1;
				mem_wdata = mem_rdata;
				gb_d      = gb_q + 1'b1;
				ge_d      = ge_q + 1'b1;
				first_d   = 1'b0;
				if (rem_eff == '0) begin
					state_d = S_FREAD;
				end else begin
					rem_d   = rem_eff - 1'b1;
					state_d = S_RREAD;
				end
			end
			S_FREAD: begin
				mem_re  = nv;
				state_d = S_FOUT;
			end
			S_FOUT: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		res.cursor_pos  = pos_ext[OW-1:0];
		res.text_length = len_ext[OW-1:0];
		res.next_valid  = nv;
		res.next_byte   = nv ? mem_rdata : '0;
		res.status      = st_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			gb_q    <= '0;
			ge_q    <= CAP_W;
			first_q <= 1'b0;
			rem_q   <= '0;
			st_q    <= gbe_pkg::ST_DONE;
		end else begin
			state_q <= state_d;
			gb_q    <= gb_d;
			ge_q    <= ge_d;
			first_q <= first_d;
			rem_q   <= rem_d;
			st_q    <= st_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			cmd_q  <= cmd;
			data_q <= data_byte;
		end
	end

	// the gap never turns negative and never runs past the store
	a_gap_order: assert property (@(posedge clk) disable iff (!arst_n)
		gb_q <= ge_q && ge_q <= CAP_W)
		else $error("gap pointers out of order");

	// copies never read and write the same entry in one cycle
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re && mem_waddr == mem_raddr))
		else $error("read and write to the same entry");

	// a right move copies at most six bytes
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RMOVE && !first_q |-> rem_q <= 3'd5)
		else $error("right move count too large");

	// text length never changes on a cursor move
	a_move_keeps_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LMOVE || state_q == S_RMOVE) |=> $stable(tlen))
		else $error("cursor move changed text length");

endmodule
